// File: src/bmp24_pkg.sv
// Shared types, constants and helpers for the 24-bit BMP stream decoder.
package bmp24_pkg;

    // Geometry bounds
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // Counter and field widths that follow from the bounds
    localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W      = $clog2(MAX_HEIGHT + 1);
    localparam int STRIDE_MAX = ((MAX_WIDTH * 3 + 3) / 4) * 4;
    localparam int OFS_W      = $clog2(STRIDE_MAX + 1);
    localparam int PROD_W     = OFS_W + HGT_W;
    localparam int NEED_W     = ((PROD_W > 31) ? PROD_W : 31) + 1;
    localparam int IDX_SUM_W  = ROW_W + WID_W + 1;

    // Fixed field widths
    localparam int POS_W = 31;
    localparam int LEN_W = 31;
    localparam int IDX_W = 24;

    // Error codes
    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_SMALL = 3'd1;
    localparam logic [2:0] ERR_SIG   = 3'd2;
    localparam logic [2:0] ERR_DEPTH = 3'd3;
    localparam logic [2:0] ERR_TRUNC = 3'd4;
    localparam logic [2:0] ERR_SIZE  = 3'd5;

    // Header constants
    localparam logic [7:0]       SIG_B    = 8'h42;
    localparam logic [7:0]       SIG_M    = 8'h4D;
    localparam logic [15:0]      BPP_24   = 16'd24;
    localparam logic [31:0]      HDR_MIN  = 32'd54;
    localparam logic [POS_W-1:0] POS_SIG2 = 31'd1;
    localparam logic [POS_W-1:0] POS_OFFSET = 31'd10;
    localparam logic [POS_W-1:0] POS_WIDTH  = 31'd18;
    localparam logic [POS_W-1:0] POS_HEIGHT = 31'd22;
    localparam logic [POS_W-1:0] POS_BPP_LO = 31'd28;
    localparam logic [POS_W-1:0] POS_BPP_HI = 31'd29;
    localparam logic [POS_W-1:0] POS_DATA   = 31'd30;
    localparam logic [POS_W-1:0] POS_MAX    = 31'h7FFF_FFFF;

    // Input request
    typedef struct packed {
        logic             file_start;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] file_size;
    } in_t;

    // Result
    typedef struct packed {
        logic             is_error;
        logic [2:0]       error_code;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [IDX_W-1:0] pixel_index;
        logic             last_pixel;
    } out_t;

    // Geometry and header check status derived from the captured fields
    typedef struct packed {
        logic             offset_ok;
        logic             width_ok;
        logic             height_ok;
        logic             fits;
        logic             top_first;
        logic [WID_W-1:0] w;
        logic [COL_W-1:0] w_m1;
        logic [ROW_W-1:0] h_m1;
        logic [OFS_W-1:0] row_bytes;
        logic [OFS_W-1:0] stride;
    } geom_t;

    // Replace one little-endian byte of a 32-bit word
    function automatic logic [31:0] put_byte(input logic [31:0] word,
                                             input logic [1:0]  sel,
                                             input logic [7:0]  b);
        logic [31:0] r;
        r = word;
        unique case (sel)
            2'd0: r[7:0]   = b;
            2'd1: r[15:8]  = b;
            2'd2: r[23:16] = b;
            2'd3: r[31:24] = b;
            default: r = word;
        endcase
        return r;
    endfunction

endpackage

// File: src/bmp24_geom.sv
// Registered image geometry and header bound checks from the captured fields.
module bmp24_geom (
    input  logic                         aclk,
    input  logic [31:0]                  pixel_data_start,
    input  logic [31:0]                  image_width,
    input  logic [31:0]                  image_height_word,
    input  logic [bmp24_pkg::LEN_W-1:0]  total_length,
    output bmp24_pkg::geom_t             geom
);
    import bmp24_pkg::*;

    logic [31:0]      h_mag;
    logic [31:0]      h_mag_m1;
    logic [31:0]      w_m1_full;
    logic [WID_W+1:0] rb_wide;
    logic [WID_W+1:0] st_wide;
    logic [PROD_W-1:0] prod;

    logic             offset_ok_reg;
    logic             width_ok_reg;
    logic             height_ok_reg;
    logic             top_first_reg;
    logic [WID_W-1:0] w_reg;
    logic [COL_W-1:0] w_m1_reg;
    logic [HGT_W-1:0] h_reg;
    logic [ROW_W-1:0] h_m1_reg;
    logic [OFS_W-1:0] row_bytes_reg;
    logic [OFS_W-1:0] stride_reg;
    logic [NEED_W-1:0] need_reg;

    // Height magnitude; the most negative value gives 2^31
    assign h_mag     = image_height_word[31] ? (32'd0 - image_height_word) : image_height_word;
    assign h_mag_m1  = h_mag - 32'd1;
    assign w_m1_full = image_width - 32'd1;

    // Row length is width*3, stride rounds it up to a multiple of four
    assign rb_wide = {2'b00, image_width[WID_W-1:0]} + {1'b0, image_width[WID_W-1:0], 1'b0};
    assign st_wide = rb_wide + (WID_W + 2)'(3);

    // First stage: bounds and per-row figures
    always_ff @(posedge aclk) begin
        offset_ok_reg <= !pixel_data_start[31] && (pixel_data_start >= HDR_MIN);
        width_ok_reg  <= !image_width[31] && (image_width != 32'd0) &&
                         (image_width <= 32'(MAX_WIDTH));
        height_ok_reg <= (h_mag != 32'd0) && (h_mag <= 32'(MAX_HEIGHT));
        top_first_reg <= image_height_word[31];
        w_reg         <= image_width[WID_W-1:0];
        w_m1_reg      <= w_m1_full[COL_W-1:0];
        h_reg         <= h_mag[HGT_W-1:0];
        h_m1_reg      <= h_mag_m1[ROW_W-1:0];
        row_bytes_reg <= OFS_W'(rb_wide);
        stride_reg    <= OFS_W'({st_wide[WID_W+1:2], 2'b00});
    end

    // Second stage: bytes the file needs for the whole image
    assign prod = PROD_W'(stride_reg) * PROD_W'(h_reg);

    always_ff @(posedge aclk) begin
        need_reg <= NEED_W'(pixel_data_start[30:0]) + NEED_W'(prod);
    end

    always_comb begin
        geom.offset_ok = offset_ok_reg;
        geom.width_ok  = width_ok_reg;
        geom.height_ok = height_ok_reg;
        geom.fits      = (need_reg <= NEED_W'(total_length));
        geom.top_first = top_first_reg;
        geom.w         = w_reg;
        geom.w_m1      = w_m1_reg;
        geom.h_m1      = h_m1_reg;
        geom.row_bytes = row_bytes_reg;
        geom.stride    = stride_reg;
    end

endmodule

// File: src/bmp24_parse.sv
// Byte parser: header capture, checks, row walk and pixel assembly.
module bmp24_parse (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         req_acc,
    input  bmp24_pkg::in_t               req,
    input  bmp24_pkg::geom_t             geom,
    output logic [31:0]                  pixel_data_start,
    output logic [31:0]                  image_width,
    output logic [31:0]                  image_height_word,
    output logic [bmp24_pkg::LEN_W-1:0]  total_length,
    output logic                         res_valid,
    output bmp24_pkg::out_t              res
);
    import bmp24_pkg::*;

    logic [POS_W-1:0] pos_reg,       pos_next;
    logic [31:0]      pds_reg,       pds_next;
    logic [31:0]      width_reg,     width_next;
    logic [31:0]      height_reg,    height_next;
    logic [7:0]       depth_lo_reg,  depth_lo_next;
    logic [LEN_W-1:0] total_reg,     total_next;
    logic             halted_reg,    halted_next;
    logic [ROW_W-1:0] src_row_reg,   src_row_next;
    logic [OFS_W-1:0] ofs_reg,       ofs_next;
    logic [1:0]       phase_reg,     phase_next;
    logic [COL_W-1:0] col_reg,       col_next;
    logic [7:0]       blue_hold_reg, blue_hold_next;
    logic [7:0]       green_hold_reg, green_hold_next;

    logic [POS_W-1:0]     cur_pos;
    logic                 cur_halt;
    logic [POS_W-1:0]     pos_sub;
    logic [15:0]          depth;
    logic                 in_row;
    logic                 last;
    logic [OFS_W:0]       ofs_inc;
    logic                 wrap;
    logic [ROW_W-1:0]     dst_row;
    logic [IDX_SUM_W-1:0] idx_sum;

    assign pixel_data_start  = pds_reg;
    assign image_width       = width_reg;
    assign image_height_word = height_reg;
    assign total_length      = total_reg;

    // A file start restarts the parser on this byte
    assign cur_pos  = req.file_start ? '0 : pos_reg;
    assign cur_halt = req.file_start ? 1'b0 : halted_reg;
    assign depth    = {req.data_byte, depth_lo_reg};

    // Pixel walk helpers
    assign in_row  = ofs_reg < geom.row_bytes;
    assign ofs_inc = {1'b0, ofs_reg} + (OFS_W + 1)'(1);
    assign wrap    = ofs_inc >= {1'b0, geom.stride};
    assign last    = (src_row_reg == geom.h_m1) && (col_reg == geom.w_m1);
    assign dst_row = geom.top_first ? src_row_reg : (geom.h_m1 - src_row_reg);
    assign idx_sum = IDX_SUM_W'(dst_row) * IDX_SUM_W'(geom.w) + IDX_SUM_W'(col_reg);

    // Next state and result
    always_comb begin
        pos_next        = pos_reg;
        pds_next        = pds_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        depth_lo_next   = depth_lo_reg;
        total_next      = total_reg;
        halted_next     = halted_reg;
        src_row_next    = src_row_reg;
        ofs_next        = ofs_reg;
        phase_next      = phase_reg;
        col_next        = col_reg;
        blue_hold_next  = blue_hold_reg;
        green_hold_next = green_hold_reg;
        res_valid       = 1'b0;
        res             = '0;
        pos_sub         = '0;

        if (req_acc) begin
            if (req.file_start) begin
                pos_next      = '0;
                pds_next      = '0;
                width_next    = '0;
                height_next   = '0;
                depth_lo_next = '0;
                total_next    = '0;
                halted_next   = 1'b0;
                src_row_next  = '0;
                ofs_next      = '0;
                phase_next    = '0;
                col_next      = '0;
            end

            if (!cur_halt) begin
                if (cur_pos != POS_MAX) begin
                    pos_next = cur_pos + POS_W'(1);
                end else begin
                    pos_next = cur_pos;
                end

                priority if (cur_pos == '0) begin
                    total_next = req.file_size;
                    if (32'(req.file_size) < HDR_MIN) begin
                        res_valid = 1'b1;
                        res.is_error = 1'b1;
                        res.error_code = ERR_SMALL;
                    end else if (req.data_byte != SIG_B) begin
                        res_valid = 1'b1;
                        res.is_error = 1'b1;
                        res.error_code = ERR_SIG;
                    end
                end else if (cur_pos == POS_SIG2) begin
                    if (req.data_byte != SIG_M) begin
                        res_valid = 1'b1;
                        res.is_error = 1'b1;
                        res.error_code = ERR_SIG;
                    end
                end else if (cur_pos >= POS_OFFSET && cur_pos <= POS_OFFSET + POS_W'(3)) begin
                    pos_sub  = cur_pos - POS_OFFSET;
                    pds_next = put_byte(pds_reg, pos_sub[1:0], req.data_byte);
                end else if (cur_pos >= POS_WIDTH && cur_pos <= POS_WIDTH + POS_W'(3)) begin
                    pos_sub    = cur_pos - POS_WIDTH;
                    width_next = put_byte(width_reg, pos_sub[1:0], req.data_byte);
                end else if (cur_pos >= POS_HEIGHT && cur_pos <= POS_HEIGHT + POS_W'(3)) begin
                    pos_sub     = cur_pos - POS_HEIGHT;
                    height_next = put_byte(height_reg, pos_sub[1:0], req.data_byte);
                end else if (cur_pos == POS_BPP_LO) begin
                    depth_lo_next = req.data_byte;
                end else if (cur_pos == POS_BPP_HI) begin
                    // Header checks, in order of precedence
                    priority if (depth != BPP_24) begin
                        res_valid = 1'b1;
                        res.is_error = 1'b1;
                        res.error_code = ERR_DEPTH;
                    end else if (!geom.offset_ok || !geom.width_ok || !geom.height_ok) begin
                        res_valid = 1'b1;
                        res.is_error = 1'b1;
                        res.error_code = ERR_SIZE;
                    end else if (!geom.fits) begin
                        res_valid = 1'b1;
                        res.is_error = 1'b1;
                        res.error_code = ERR_TRUNC;
                    end else begin
                        // header accepted, pixel data follows
                        res_valid = 1'b0;
                    end
                end else if (cur_pos >= POS_DATA && {1'b0, cur_pos} >= pds_reg) begin
                    // Pixel data: BGR triples, then padding to the stride
                    if (in_row) begin
                        unique case (phase_reg)
                            2'd0: begin
                                blue_hold_next = req.data_byte;
                                phase_next     = 2'd1;
                            end
                            2'd1: begin
                                green_hold_next = req.data_byte;
                                phase_next      = 2'd2;
                            end
                            default: begin
                                res_valid       = 1'b1;
                                res.red         = req.data_byte;
                                res.green       = green_hold_reg;
                                res.blue        = blue_hold_reg;
                                res.pixel_index = IDX_W'(idx_sum);
                                res.last_pixel  = last;
                                phase_next      = 2'd0;
                                col_next        = col_reg + COL_W'(1);
                            end
                        endcase
                    end
                    if (wrap) begin
                        ofs_next     = '0;
                        src_row_next = src_row_reg + ROW_W'(1);
                        phase_next   = '0;
                        col_next     = '0;
                    end else begin
                        ofs_next = ofs_inc[OFS_W-1:0];
                    end
                    if (res_valid && last) begin
                        halted_next = 1'b1;
                    end
                end else begin
                    // unused header bytes and the gap before the pixel data
                    res_valid = 1'b0;
                end

                if (res_valid && res.is_error) begin
                    halted_next = 1'b1;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            pds_reg      <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            depth_lo_reg <= '0;
            total_reg    <= '0;
            halted_reg   <= 1'b0;
            src_row_reg  <= '0;
            ofs_reg      <= '0;
            phase_reg    <= '0;
            col_reg      <= '0;
        end else begin
            pos_reg      <= pos_next;
            pds_reg      <= pds_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            depth_lo_reg <= depth_lo_next;
            total_reg    <= total_next;
            halted_reg   <= halted_next;
            src_row_reg  <= src_row_next;
            ofs_reg      <= ofs_next;
            phase_reg    <= phase_next;
            col_reg      <= col_next;
        end
    end

    // Held color bytes
    always_ff @(posedge aclk) begin
        blue_hold_reg  <= blue_hold_next;
        green_hold_reg <= green_hold_next;
    end

endmodule

// File: src/bmp24_out_reg.sv
// Result register between the parser and the result channel.
module bmp24_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  bmp24_pkg::out_t  in_data,
    output logic             in_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output bmp24_pkg::out_t  m_data
);
    import bmp24_pkg::*;

    logic valid_reg, valid_next;
    out_t data_reg;

    // Load whenever the held result leaves or nothing is held
    assign in_ready   = !valid_reg || m_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// File: src/bmp24_to_rgb_stream_decoder.sv
// Top level of the 24-bit BMP to RGB pixel stream decoder.
//
// Input channel (s_): one file byte per request, with the file's total length
// and a flag on its first byte; the flag restarts the parser on that byte.
// Result channel (m_): at most one result per input byte, either an RGB pixel
// with its top-down destination index and a last flag, or one error status.
// After an error or the last pixel, bytes are dropped until the next start.
// Results are registered: a result appears on m_ in the cycle after the byte that causes it.
// Throughput: one byte per cycle while s_ready is high; the parser state and
// the result register both update on each accepted byte, and the header
// geometry settles after the height bytes, well before the bit-depth check.
// Stall: s_ready falls only while a result is held and m_ready is low;
// the held result stays unchanged until taken.
// Reset (aresetn low, synchronous): parser back to byte 0, result channel
// empty; the first byte afterwards counts as the start of a file.
module bmp24_to_rgb_stream_decoder (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bmp24_pkg::in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output bmp24_pkg::out_t  m_data
);
    import bmp24_pkg::*;

    logic                 req_acc;
    logic                 res_valid;
    out_t                 res;
    geom_t                geom;
    logic [31:0]          pixel_data_start;
    logic [31:0]          image_width;
    logic [31:0]          image_height_word;
    logic [LEN_W-1:0]     total_length;

    assign req_acc = s_valid && s_ready;

    bmp24_geom u_geom (
        .aclk              (aclk),
        .pixel_data_start  (pixel_data_start),
        .image_width       (image_width),
        .image_height_word (image_height_word),
        .total_length      (total_length),
        .geom              (geom)
    );

    bmp24_parse u_parse (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .req_acc           (req_acc),
        .req               (s_data),
        .geom              (geom),
        .pixel_data_start  (pixel_data_start),
        .image_width       (image_width),
        .image_height_word (image_height_word),
        .total_length      (total_length),
        .res_valid         (res_valid),
        .res               (res)
    );

    bmp24_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_data  (res),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // Error results carry a real code and blank pixel fields
    a_err_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.is_error) |->
            (m_data.error_code != ERR_NONE) && (m_data.error_code <= ERR_SIZE) &&
            (m_data.pixel_index == '0) && !m_data.last_pixel &&
            (m_data.red == 8'd0) && (m_data.green == 8'd0) && (m_data.blue == 8'd0))
        else $error("error result with bad fields");

    // Pixel results carry no error code
    a_pix_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.is_error) |-> (m_data.error_code == ERR_NONE))
        else $error("pixel result with error code");

    // No result appears without an accepted byte
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        (!(s_valid && s_ready) && !(m_valid && !m_ready)) |=> !m_valid)
        else $error("result without request");

endmodule

// File: sim/bmp24_decode_tracker_pkg.sv
// Scoreboard class that predicts the decoder's pixel and error results from the bytes it takes.
`timescale 1ns / 1ps
package bmp24_decode_tracker_pkg;
    import bmp24_pkg::*;

    class bmp_decode_tracker;
        // Parser state, mirrored from what the decoder should hold
        bit [30:0]   byte_pos;
        bit [31:0]   data_ofs;
        bit [31:0]   width_raw;
        bit [31:0]   height_word;
        bit [15:0]   depth;
        bit [30:0]   file_len;
        bit          stopped;
        int unsigned src_row;
        int unsigned row_ofs;
        bit [7:0]    blue_q;
        bit [7:0]    green_q;

        // Pixels and error statuses still owed by the decoder, oldest first
        out_t        pending_pixels[$];
        int          mismatches;
        int          parsed_bytes;

        function void restart();
            byte_pos    = '0;
            data_ofs    = '0;
            width_raw   = '0;
            height_word = '0;
            depth       = '0;
            file_len    = '0;
            stopped     = 1'b0;
            src_row     = 0;
            row_ofs     = 0;
            blue_q      = '0;
            green_q     = '0;
        endfunction

        function new();
            restart();
            mismatches   = 0;
            parsed_bytes = 0;
        endfunction

        // Most negative height wraps to 2^31, which is out of bounds anyway
        function bit [31:0] height_mag();
            return height_word[31] ? 32'd0 - height_word : height_word;
        endfunction

        function void push_error(logic [2:0] code);
            out_t r;
            r            = '0;
            r.is_error   = 1'b1;
            r.error_code = code;
            pending_pixels.push_back(r);
            stopped = 1'b1;
        endfunction

        // Runs once the depth's high byte is in; order of checks matters
        function void run_header_checks();
            bit [31:0] hm;
            bit [63:0] stride;
            bit [63:0] need;
            hm = height_mag();
            if (depth != BPP_24) begin
                push_error(ERR_DEPTH);
            end else if (data_ofs[31] || data_ofs < HDR_MIN) begin
                push_error(ERR_SIZE);
            end else if (width_raw[31] || width_raw == 0 || width_raw > MAX_WIDTH) begin
                push_error(ERR_SIZE);
            end else if (hm == 0 || hm > MAX_HEIGHT) begin
                push_error(ERR_SIZE);
            end else begin
                stride = ({32'd0, width_raw} * 3 + 3) & ~64'd3;
                need   = {32'd0, data_ofs} + stride * {32'd0, hm};
                if (need > {33'd0, file_len})
                    push_error(ERR_TRUNC);
            end
        endfunction

        // One byte of pixel data: BGR in, RGB out on the third byte, padding skipped
        function void take_pixel_byte(bit [7:0] b);
            int unsigned w;
            int unsigned hm;
            int unsigned row_bytes;
            int unsigned stride;
            int unsigned col;
            int unsigned dst_row;
            out_t        r;
            w         = width_raw;
            hm        = height_mag();
            row_bytes = w * 3;
            stride    = (row_bytes + 3) & ~32'd3;
            if (row_ofs < row_bytes) begin
                col = row_ofs / 3;
                // byte phase within the triple: blue, green, then red
                case (row_ofs % 3)
                    0: blue_q = b;
                    1: green_q = b;
                    default: begin
                        dst_row       = height_word[31] ? src_row : hm - 1 - src_row;
                        r             = '0;
                        r.red         = b;
                        r.green       = green_q;
                        r.blue        = blue_q;
                        r.pixel_index = 24'(dst_row * w + col);
                        r.last_pixel  = (src_row == hm - 1) && (col == w - 1);
                        pending_pixels.push_back(r);
                        if (r.last_pixel)
                            stopped = 1'b1;
                    end
                endcase
            end
            row_ofs++;
            if (row_ofs >= stride) begin
                row_ofs = 0;
                src_row++;
            end
        endfunction

        // Called for every accepted request
        function void note_byte(in_t req);
            bit [30:0] pos;
            bit [7:0]  b;
            if (req.file_start)
                restart();
            if (stopped)
                return;
            parsed_bytes++;
            pos = byte_pos;
            b   = req.data_byte;
            if (pos == 0) begin
                file_len = req.file_size;
                if (file_len < HDR_MIN)
                    push_error(ERR_SMALL);
                else if (b != SIG_B)
                    push_error(ERR_SIG);
            end else if (pos == POS_SIG2) begin
                if (b != SIG_M)
                    push_error(ERR_SIG);
            end else if (pos >= POS_OFFSET && pos < POS_OFFSET + 4) begin
                data_ofs[8 * (pos - POS_OFFSET) +: 8] = b;
            end else if (pos >= POS_WIDTH && pos < POS_WIDTH + 4) begin
                width_raw[8 * (pos - POS_WIDTH) +: 8] = b;
            end else if (pos >= POS_HEIGHT && pos < POS_HEIGHT + 4) begin
                height_word[8 * (pos - POS_HEIGHT) +: 8] = b;
            end else if (pos == POS_BPP_LO) begin
                depth[7:0] = b;
            end else if (pos == POS_BPP_HI) begin
                depth[15:8] = b;
                run_header_checks();
            end else if (pos >= POS_DATA && pos >= data_ofs) begin
                take_pixel_byte(b);
            end
            if (byte_pos != POS_MAX)
                byte_pos++;
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d got %0d", $time, field, want, got);
                mismatches++;
            end
        endfunction

        // Called for every accepted result
        function void check_output(out_t got);
            out_t want;
            if (pending_pixels.size() == 0) begin
                $display("%0t: result %h with nothing awaited", $time, got);
                mismatches++;
                return;
            end
            want = pending_pixels.pop_front();
            compare_field("is_error", want.is_error, got.is_error);
            compare_field("error_code", want.error_code, got.error_code);
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
            compare_field("pixel_index", want.pixel_index, got.pixel_index);
            compare_field("last_pixel", want.last_pixel, got.last_pixel);
        endfunction
    endclass

endpackage

// File: sim/bmp24_to_rgb_stream_decoder_test.sv
// Testbench top: streams BMP files into the decoder and checks every result it returns.
`timescale 1ns / 1ps
module bmp24_to_rgb_stream_decoder_test;
    import bmp24_pkg::*;
    import bmp24_decode_tracker_pkg::*;

    localparam int          RANDOM_ITEMS = 450;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          QUIET_LIMIT  = 5000;
    localparam logic [15:0] SIG_BM       = {SIG_B, SIG_M};

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    bit hold_req     = 1'b0;
    int quiet_cycles = 0;

    bmp_decode_tracker tracker = new();

    bmp24_to_rgb_stream_decoder uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 100 MHz clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Monitor and watchdog: both channels sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                tracker.check_output(m_data);
            if (s_valid && s_ready)
                tracker.note_byte(s_data);
            if ((m_valid && m_ready) || (s_valid && s_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
                $display("FAIL bmp24_to_rgb_stream_decoder");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_ready <= !(sink_idle_en && $urandom_range(99) < 26);
            end
        end
    end

    // One request: optional idle gaps, then hold valid until accepted
    task automatic send_byte(input in_t req);
        @(negedge aclk);
        while (src_idle_en && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Bytes a well-formed file needs: data offset plus padded rows
    function automatic longint unsigned image_len(bit [31:0] ofs, bit [31:0] w, bit [31:0] h);
        longint unsigned hm;
        longint unsigned stride;
        hm     = h[31] ? 32'd0 - h : h;
        stride = ((longint'(w) * 3 + 3) / 4) * 4;
        return longint'(ofs) + stride * hm;
    endfunction

    // Stream n_bytes of a BMP image built from the given header fields
    task automatic send_bmp(input bit mark_start, input bit [15:0] sig, input bit [31:0] ofs,
                            input bit [31:0] w, input bit [31:0] h, input bit [15:0] bpp,
                            input bit [30:0] fsize, input int n_bytes);
        in_t      req;
        bit [7:0] b;
        for (int i = 0; i < n_bytes; i++) begin
            if (i == 0)
                b = sig[15:8];
            else if (i == POS_SIG2)
                b = sig[7:0];
            else if (i >= POS_OFFSET && i < POS_OFFSET + 4)
                b = ofs[8 * (i - POS_OFFSET) +: 8];
            else if (i >= POS_WIDTH && i < POS_WIDTH + 4)
                b = w[8 * (i - POS_WIDTH) +: 8];
            else if (i >= POS_HEIGHT && i < POS_HEIGHT + 4)
                b = h[8 * (i - POS_HEIGHT) +: 8];
            else if (i == POS_BPP_LO)
                b = bpp[7:0];
            else if (i == POS_BPP_HI)
                b = bpp[15:8];
            else
                b = 8'($urandom);
            req.file_start = mark_start && (i == 0);
            req.data_byte  = b;
            // size only counts on the first byte; garbage elsewhere
            req.file_size  = (i == 0) ? fsize : 31'($urandom);
            send_byte(req);
        end
    endtask

    task automatic send_good(input bit [31:0] w, input bit [31:0] h, input bit [31:0] ofs,
                             input int trail);
        longint unsigned need;
        need = image_len(ofs, w, h);
        send_bmp(1'b1, SIG_BM, ofs, w, h, BPP_24, 31'(need), int'(need) + trail);
    endtask

    // Mostly well-formed small files; some header faults, cut-off files and noise
    task automatic send_random_file();
        bit [31:0]       w;
        bit [31:0]       h;
        bit [31:0]       hm;
        bit [31:0]       ofs;
        bit [15:0]       bpp;
        bit [15:0]       sig;
        bit [30:0]       fsize;
        longint unsigned need;
        int              pick;
        int              n;
        w     = $urandom_range(5, 1);
        hm    = $urandom_range(3, 1);
        h     = $urandom_range(1) ? 32'd0 - hm : hm;
        ofs   = ($urandom_range(3) == 0) ? 54 + $urandom_range(10, 1) : 54;
        bpp   = BPP_24;
        sig   = SIG_BM;
        need  = image_len(ofs, w, h);
        fsize = 31'(need);
        n     = int'(need) + $urandom_range(3);
        pick  = $urandom_range(99);
        if (pick < 65) begin
            if ($urandom_range(3) == 0)
                fsize = 31'(need + $urandom_range(200, 1));
            else if ($urandom_range(7) == 0)
                fsize = 31'($urandom_range(32'h7FFF_FFFF, 32'h4000_0000));
        end else if (pick < 80) begin
            n = 30 + $urandom_range(4);
            case ($urandom_range(6))
                0: begin
                    bpp = 16'($urandom);
                    if (bpp == BPP_24)
                        bpp = '0;
                end
                1: ofs = $urandom_range(1) ? $urandom_range(53) : {1'b1, 31'($urandom)};
                2: case ($urandom_range(2))
                    0: w = 0;
                    1: w = $urandom_range(32'h7FFF_FFFF, MAX_WIDTH + 1);
                    default: w = {1'b1, 31'($urandom)};
                endcase
                3: case ($urandom_range(2))
                    0: h = 0;
                    1: h = $urandom_range(32'h7FFF_FFFF, MAX_HEIGHT + 1);
                    default: h = 32'd0 - $urandom_range(32'h8000_0000, MAX_HEIGHT + 1);
                endcase
                4: fsize = 31'(need - $urandom_range(int'(need) - 54, 1));
                5: begin
                    sig = $urandom_range(1) ? {SIG_B, 8'($urandom)} : 16'($urandom);
                    if (sig == SIG_BM)
                        sig = {SIG_B, ~SIG_M};
                end
                default: fsize = $urandom_range(53);
            endcase
        end else if (pick < 90) begin
            // file abandoned part-way; the next start must restart the parser
            n = $urandom_range(int'(need) - 1, 2);
        end else begin
            sig   = 16'($urandom);
            ofs   = $urandom;
            w     = $urandom;
            h     = $urandom;
            bpp   = 16'($urandom);
            fsize = 31'($urandom);
            n     = $urandom_range(40, 1);
        end
        send_bmp(1'b1, sig, ofs, w, h, bpp, fsize, n);
    endtask

    // Main sequence
    initial begin
        int base;
        int done;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // First file right after reset carries no start flag; trailing bytes ignored
        send_bmp(1'b0, SIG_BM, 54, 1, 1, BPP_24, 31'(image_len(54, 1, 1)), 62);
        // Top-down with a gap before the data, bottom-up with padding, no padding
        send_good(2, 32'd0 - 3, 60, 2);
        send_good(3, 2, 54, 0);
        send_good(4, 2, 54, 3);
        // Size and signature faults
        send_bmp(1'b1, SIG_BM, 54, 1, 1, BPP_24, 53, 4);
        send_bmp(1'b1, SIG_BM, 54, 1, 1, BPP_24, 0, 3);
        send_bmp(1'b1, {8'h58, SIG_M}, 54, 1, 1, BPP_24, 31'h7FFF_FFFF, 3);
        send_bmp(1'b1, {SIG_B, 8'h58}, 54, 1, 1, BPP_24, 31'h7FFF_FFFF, 3);
        // Depth faults, including one that also has a bad width
        send_bmp(1'b1, SIG_BM, 54, 1, 1, 16'd32, 31'h7FFF_FFFF, 34);
        send_bmp(1'b1, SIG_BM, 54, 1, 1, 16'h0118, 31'h7FFF_FFFF, 34);
        send_bmp(1'b1, SIG_BM, 54, 0, 2, 16'd16, 31'h7FFF_FFFF, 34);
        // Geometry out of bounds
        send_bmp(1'b1, SIG_BM, 53, 1, 1, BPP_24, 31'h7FFF_FFFF, 34);
        send_bmp(1'b1, SIG_BM, 32'h8000_0036, 1, 1, BPP_24, 31'h7FFF_FFFF, 34);
        send_bmp(1'b1, SIG_BM, 40, 2, 2, BPP_24, 60, 34);
        send_bmp(1'b1, SIG_BM, 54, 0, 1, BPP_24, 31'h7FFF_FFFF, 34);
        send_bmp(1'b1, SIG_BM, 54, MAX_WIDTH + 1, 1, BPP_24, 31'h7FFF_FFFF, 34);
        send_bmp(1'b1, SIG_BM, 54, 32'hFFFF_FFFF, 1, BPP_24, 31'h7FFF_FFFF, 34);
        send_bmp(1'b1, SIG_BM, 54, 1, 0, BPP_24, 31'h7FFF_FFFF, 34);
        send_bmp(1'b1, SIG_BM, 54, 1, MAX_HEIGHT + 1, BPP_24, 31'h7FFF_FFFF, 34);
        send_bmp(1'b1, SIG_BM, 54, 1, 32'h8000_0000, BPP_24, 31'h7FFF_FFFF, 34);
        send_bmp(1'b1, SIG_BM, 54, 1, 32'd0 - (MAX_HEIGHT + 1), BPP_24, 31'h7FFF_FFFF, 34);
        // Widest and tallest bounds pass the size check, then fail as cut off
        send_bmp(1'b1, SIG_BM, 54, MAX_WIDTH, 1, BPP_24,
                 31'(image_len(54, MAX_WIDTH, 1) - 1), 34);
        send_bmp(1'b1, SIG_BM, 54, 1, 32'd0 - MAX_HEIGHT, BPP_24,
                 31'(image_len(54, 1, MAX_HEIGHT) - 1), 34);
        // Largest image header is accepted; the file is then abandoned
        send_bmp(1'b1, SIG_BM, 54, MAX_WIDTH, MAX_HEIGHT, BPP_24,
                 31'(image_len(54, MAX_WIDTH, MAX_HEIGHT)), 40);
        // Truncated by one byte
        send_bmp(1'b1, SIG_BM, 54, 3, 2, BPP_24, 31'(image_len(54, 3, 2) - 1), 36);
        // Restart in the middle of the pixel data
        send_bmp(1'b1, SIG_BM, 54, 5, 3, BPP_24, 31'(image_len(54, 5, 3)), 70);

        // Wide image, no idling, receiver holds off so the input backs up
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        hold_req     = 1'b1;
        send_good(20, 2, 54, 0);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        // Tall narrow image, bottom-up
        send_good(1, 24, 54, 1);

        // Random files, with one stretch of back-to-back traffic
        base = tracker.parsed_bytes;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            src_idle_en  = !(done >= 100 && done < 320);
            sink_idle_en = src_idle_en;
            send_random_file();
            done = tracker.parsed_bytes - base;
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;

        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.pending_pixels.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending_pixels.size() == 0) begin
            $display("PASS bmp24_to_rgb_stream_decoder");
        end else begin
            $display("FAIL bmp24_to_rgb_stream_decoder");
        end
        $finish;
    end

endmodule

// File: sim.f
src/bmp24_pkg.sv
src/bmp24_geom.sv
src/bmp24_parse.sv
src/bmp24_out_reg.sv
src/bmp24_to_rgb_stream_decoder.sv
sim/bmp24_decode_tracker_pkg.sv
sim/bmp24_to_rgb_stream_decoder_test.sv
